FILE: rtl/l2dd_pkg.sv
// Shared types, codes and constants for the discovery responder with duplicate suppression.
// Used by the controller, the datapath and the top level. Depends on nothing.
`default_nettype none

package l2dd_pkg;

	// Duplicate table geometry.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int MAC_W       = 48;
	localparam int TIME_W      = 32;
	localparam int ENTRY_W     = MAC_W + TIME_W;

	// Frame checks.
	localparam logic [10:0] MIN_FRAME_LEN = 11'd60;
	localparam logic [7:0]  VERSION_ONE   = 8'h01;
	localparam logic [7:0]  MSG_PROBE     = 8'h01;
	localparam logic [7:0]  MSG_RESPONSE  = 8'h02;
	localparam logic [7:0]  ADDR_IPV4     = 8'h04;
	localparam logic [7:0]  ADDR_IPV6     = 8'h06;
	localparam logic [7:0]  TTL_RESET     = 8'd5;

	typedef enum logic [2:0] {
		REG_OWN_MAC       = 3'd0,
		REG_OWN_ADDR_TYPE = 3'd1,
		REG_OWN_IP_HIGH   = 3'd2,
		REG_OWN_IP_LOW    = 3'd3,
		REG_TTL_SECONDS   = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		V_SHORT       = 4'd0,
		V_SELF        = 4'd1,
		V_BAD_VERSION = 4'd2,
		V_BAD_SENDER  = 4'd3,
		V_SUPPRESSED  = 4'd4,
		V_RESPOND     = 4'd5,
		V_NOT_FOR_US  = 4'd6,
		V_BOUND       = 4'd7,
		V_UNKNOWN     = 4'd8
	} verdict_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic decide;
		logic issue;
		logic update;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_walk;
		logic cnt_zero;
		logic last_issue;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/l2_discovery_responder_dedup_core.sv
// Top level of the discovery responder with duplicate suppression.
// Joins l2dd_ctrl and l2dd_datapath; depends on l2dd_pkg.
//
// The input channel (in_valid/in_ready) carries one parsed discovery frame per item with
// its seconds timestamp. The output channel (out_valid/out_ready) returns exactly one
// result item per input item, in order: a verdict code and, for a response to send or a
// completed binding, the peer MAC, type and 16-byte address (zero otherwise). Registers
// are written through cfg_we/cfg_index/cfg_wdata, one per cycle, and only while the
// block is idle; the user is bound to this, and the block itself does not enforce it.
// A frame that is dropped, a response or an unknown type passes through the accept,
// decide and finish states. A probe from a valid sender walks the duplicate table over
// the entries held (at most 32), one RAM read per cycle through the single read port,
// then drains the last read, updates the table and finishes; with an empty table it
// skips the walk and the drain. No new item is accepted before the last one finishes.
// arst_n clears the entry count and the control state and loads the register reset values
// (suppression window 5 seconds). Table contents are not cleared; only entries below the
// count are ever compared.
// The result sits in an output register. A new item is taken while it waits; the
// following result is held back, and no further item is accepted, until the receiver
// takes the waiting one.
`default_nettype none

module l2_discovery_responder_dedup_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [10:0] frame_length,
	input  wire logic [47:0] source_mac,
	input  wire logic [7:0]  proto_version,
	input  wire logic [7:0]  message_type,
	input  wire logic [7:0]  sender_type,
	input  wire logic [63:0] sender_ip_high,
	input  wire logic [63:0] sender_ip_low,
	input  wire logic [7:0]  target_type,
	input  wire logic [63:0] target_ip_high,
	input  wire logic [63:0] target_ip_low,
	input  wire logic [31:0] now_seconds,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       verdict,
	output logic [47:0]      peer_mac,
	output logic [7:0]       peer_addr_type,
	output logic [63:0]      peer_ip_high,
	output logic [63:0]      peer_ip_low
);

	// Commands flow from the controller to the datapath, status flows back.
	l2dd_pkg::dp_cmd_t cmd;
	l2dd_pkg::dp_sts_t sts;

	l2dd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration, the captured item, the duplicate table
	// and the result register.
	l2dd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.frame_length   (frame_length),
		.source_mac     (source_mac),
		.proto_version  (proto_version),
		.message_type   (message_type),
		.sender_type    (sender_type),
		.sender_ip_high (sender_ip_high),
		.sender_ip_low  (sender_ip_low),
		.target_type    (target_type),
		.target_ip_high (target_ip_high),
		.target_ip_low  (target_ip_low),
		.now_seconds    (now_seconds),
		.cmd            (cmd),
		.sts            (sts),
		.verdict        (verdict),
		.peer_mac       (peer_mac),
		.peer_addr_type (peer_addr_type),
		.peer_ip_high   (peer_ip_high),
		.peer_ip_low    (peer_ip_low)
	);

endmodule

`default_nettype wire

FILE: rtl/l2dd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the duplicate table.
`default_nettype none

module l2dd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/l2dd_ctrl.sv
// Sequencing state machine: accept, classify, table walk, table update, result hand-off.
// Depends on l2dd_pkg for the command and status structs.
`default_nettype none

module l2dd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire l2dd_pkg::dp_sts_t sts,
	output l2dd_pkg::dp_cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_WALK   = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (!sts.need_walk) begin
					state_d = ST_FINISH;
				end else if (sts.cnt_zero) begin
					state_d = ST_UPDATE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last entry read is compared during this cycle.
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/l2dd_datapath.sv
// Datapath: configuration registers, captured item, frame checks, duplicate table walk,
// victim selection and the result register. Depends on l2dd_pkg and l2dd_ram.
`default_nettype none

module l2dd_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [63:0]       cfg_wdata,
	input  wire logic [10:0]       frame_length,
	input  wire logic [47:0]       source_mac,
	input  wire logic [7:0]        proto_version,
	input  wire logic [7:0]        message_type,
	input  wire logic [7:0]        sender_type,
	input  wire logic [63:0]       sender_ip_high,
	input  wire logic [63:0]       sender_ip_low,
	input  wire logic [7:0]        target_type,
	input  wire logic [63:0]       target_ip_high,
	input  wire logic [63:0]       target_ip_low,
	input  wire logic [31:0]       now_seconds,
	input  wire l2dd_pkg::dp_cmd_t cmd,
	output l2dd_pkg::dp_sts_t      sts,
	output logic [3:0]             verdict,
	output logic [47:0]            peer_mac,
	output logic [7:0]             peer_addr_type,
	output logic [63:0]            peer_ip_high,
	output logic [63:0]            peer_ip_low
);

	localparam int IW = l2dd_pkg::IDX_W;
	localparam int CW = l2dd_pkg::CNT_W;

	// Configuration.
	logic [47:0] own_mac_q;
	logic [7:0]  own_type_q;
	logic [63:0] own_ip_high_q;
	logic [63:0] own_ip_low_q;
	logic [7:0]  ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q     <= '0;
			own_type_q    <= '0;
			own_ip_high_q <= '0;
			own_ip_low_q  <= '0;
			ttl_q         <= l2dd_pkg::TTL_RESET;
		end else if (cfg_we) begin
			unique case (l2dd_pkg::cfg_reg_t'(cfg_index))
				l2dd_pkg::REG_OWN_MAC:       own_mac_q     <= cfg_wdata[47:0];
				l2dd_pkg::REG_OWN_ADDR_TYPE: own_type_q    <= cfg_wdata[7:0];
				l2dd_pkg::REG_OWN_IP_HIGH:   own_ip_high_q <= cfg_wdata;
				l2dd_pkg::REG_OWN_IP_LOW:    own_ip_low_q  <= cfg_wdata;
				l2dd_pkg::REG_TTL_SECONDS:   ttl_q         <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Captured item.
	logic [10:0] len_q;
	logic [47:0] smac_q;
	logic [7:0]  ver_q;
	logic [7:0]  msg_q;
	logic [7:0]  stype_q;
	logic [63:0] sip_hi_q;
	logic [63:0] sip_lo_q;
	logic [7:0]  ttype_q;
	logic [63:0] tip_hi_q;
	logic [63:0] tip_lo_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			len_q    <= frame_length;
			smac_q   <= source_mac;
			ver_q    <= proto_version;
			msg_q    <= message_type;
			stype_q  <= sender_type;
			sip_hi_q <= sender_ip_high;
			sip_lo_q <= sender_ip_low;
			ttype_q  <= target_type;
			tip_hi_q <= target_ip_high;
			tip_lo_q <= target_ip_low;
			now_q    <= now_seconds;
		end
	end

	// Frame checks in priority order.
	l2dd_pkg::verdict_t early_verdict;
	logic               need_walk;

	always_comb begin
		need_walk = 1'b0;
		priority if (len_q < l2dd_pkg::MIN_FRAME_LEN) begin
			early_verdict = l2dd_pkg::V_SHORT;
		end else if (smac_q == own_mac_q) begin
			early_verdict = l2dd_pkg::V_SELF;
		end else if (ver_q != l2dd_pkg::VERSION_ONE) begin
			early_verdict = l2dd_pkg::V_BAD_VERSION;
		end else if (msg_q == l2dd_pkg::MSG_PROBE) begin
			if (stype_q != l2dd_pkg::ADDR_IPV4 && stype_q != l2dd_pkg::ADDR_IPV6) begin
				early_verdict = l2dd_pkg::V_BAD_SENDER;
			end else begin
				early_verdict = l2dd_pkg::V_RESPOND;
				need_walk     = 1'b1;
			end
		end else if (msg_q == l2dd_pkg::MSG_RESPONSE) begin
			if (ttype_q == own_type_q && tip_hi_q == own_ip_high_q &&
			    tip_lo_q == own_ip_low_q) begin
				early_verdict = l2dd_pkg::V_BOUND;
			end else begin
				early_verdict = l2dd_pkg::V_NOT_FOR_US;
			end
		end else begin
			early_verdict = l2dd_pkg::V_UNKNOWN;
		end
	end

	// Table walk: one read issued per cycle, compared in the cycle after it is issued.
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            cmp_vld_s1;
	logic [IW-1:0]   cmp_idx_s1;
	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;
	logic [31:0]     hit_age_q;
	logic [IW-1:0]   victim_q;
	logic [31:0]     worst_q;

	logic [l2dd_pkg::ENTRY_W-1:0] rd_data;
	logic [47:0]     rd_mac;
	logic [31:0]     rd_seen;
	logic [31:0]     rd_age;
	logic            suppress;
	logic            table_full;
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;

	assign {rd_mac, rd_seen} = rd_data;
	assign rd_age     = now_q - rd_seen;
	assign suppress   = hit_q && (hit_age_q < {24'd0, ttl_q});
	assign table_full = (count_q == CW'(l2dd_pkg::TABLE_DEPTH));
	assign ram_we     = cmd.update && !suppress;

	always_comb begin
		priority if (hit_q) begin
			ram_waddr = hit_idx_q;
		end else if (!table_full) begin
			ram_waddr = count_q[IW-1:0];
		end else begin
			ram_waddr = victim_q;
		end
	end

	l2dd_ram #(
		.WIDTH(l2dd_pkg::ENTRY_W),
		.DEPTH(l2dd_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({smac_q, now_q}),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	assign sts.need_walk  = need_walk;
	assign sts.cnt_zero   = (count_q == '0);
	assign sts.last_issue = (idx_q == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.decide) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (cmp_vld_s1 && !hit_q && rd_mac == smac_q) begin
					hit_q <= 1'b1;
				end
			end
			if (ram_we && !hit_q && !table_full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// First match wins; the oldest entry, lowest index on equal ages, is the victim.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cmp_idx_s1 <= idx_q[IW-1:0];
		end
		if (cmp_vld_s1) begin
			if (!hit_q && rd_mac == smac_q) begin
				hit_idx_q <= cmp_idx_s1;
				hit_age_q <= rd_age;
			end
			if (cmp_idx_s1 == '0 || rd_age > worst_q) begin
				worst_q  <= rd_age;
				victim_q <= cmp_idx_s1;
			end
		end
	end

	// Verdict and result register.
	l2dd_pkg::verdict_t verdict_q;
	l2dd_pkg::verdict_t out_verdict_q;
	logic               give_peer;

	assign give_peer = (verdict_q == l2dd_pkg::V_RESPOND) || (verdict_q == l2dd_pkg::V_BOUND);

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			verdict_q <= early_verdict;
		end else if (cmd.update) begin
			verdict_q <= suppress ? l2dd_pkg::V_SUPPRESSED : l2dd_pkg::V_RESPOND;
		end
		if (cmd.load_out) begin
			out_verdict_q  <= verdict_q;
			peer_mac       <= give_peer ? smac_q   : '0;
			peer_addr_type <= give_peer ? stype_q  : '0;
			peer_ip_high   <= give_peer ? sip_hi_q : '0;
			peer_ip_low    <= give_peer ? sip_lo_q : '0;
		end
	end

	assign verdict = out_verdict_q;

endmodule

`default_nettype wire
